>>> hdl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 digest engine package
// Shared types, command struct and constants for the controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

    // Number of rounds per 512-bit block and the index of the final round.
    localparam int unsigned ROUNDS = 80;
    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

    // Window fill level at which the length words follow.
    localparam logic [3:0] LEN_SLOT = 4'd14;
    localparam logic [3:0] LAST_SLOT = 4'd15;

    // Digest words and the index of the final one.
    localparam int unsigned DIGEST_WORDS = 5;
    localparam logic [2:0] LAST_DIGEST_IDX = 3'(DIGEST_WORDS - 1);

    // Byte count of a full word.
    localparam logic [2:0] FULL_BYTES = 3'd4;

    // Initial hash values, entry 0 listed last.
    localparam logic [4:0][31:0] INIT_HASH = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    // Round constants.
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    // Padding marker byte in the top byte lane.
    localparam logic [31:0] PAD_MARK_WORD = 32'h80000000;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_MARK,
        S_PAD_ZERO,
        S_LEN_HI,
        S_LEN_LO,
        S_ROUND,
        S_ADD,
        S_DONE
    } t_state;

    // Source of a word pushed into the schedule window.
    typedef enum logic [2:0] {
        PS_INPUT,
        PS_MARK,
        PS_ZERO,
        PS_LEN_HI,
        PS_LEN_LO
    } t_push_sel;

    // Commands from controller to datapath.
    typedef struct packed {
        logic      push;
        t_push_sel push_sel;
        logic      start_block;
        logic      round_en;
        logic [6:0] round_idx;
        logic      chain_add;
        logic      digest_load;
        logic      out_shift;
    } t_dp_cmd;

    // Byte count saturated to a full word.
    function automatic logic [2:0] sat_count(input logic [2:0] n);
        return (n > FULL_BYTES) ? FULL_BYTES : n;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sha1_message_digest_core.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Hashes a word stream and returns the five-word digest per message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): one big-endian message word per
//   handshake, first byte in bits 31..24. Words before the last always count
//   as four bytes; the word with i_last_item set carries 0 to 4 bytes.
//   Output channel (o_out_valid / i_out_ready): five digest words, index 0
//   (most significant) first, o_last_word set on the fifth.
// Intake and compression:
//   A word is taken on each handshake while the core is idle. Every sixteenth
//   word starts a compression of 80 rounds (one round per cycle) and then the
//   chaining add, with intake stalled until both are through. After the last
//   word the padding words follow one per cycle outside compressions, then
//   one or two blocks run; S_DONE loads the digest when the buffer is free.
// Reset and stalls:
//   Synchronous reset restores the initial hash values and clears the length.
//   The digest sits in its own buffer, so the next message streams in while
//   the receiver stalls; only the next message's digest load waits for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    sha1_pkg::t_dp_cmd cmd;

    // Sequencer.
    sha1_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_byte_count (i_byte_count),
        .i_last_item  (i_last_item),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .o_cmd        (cmd)
    );

    // Hash datapath.
    sha1_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_word   (i_data_word),
        .i_byte_count  (i_byte_count),
        .i_last_item   (i_last_item),
        .o_digest_word (o_digest_word)
    );

endmodule

`default_nettype wire

>>> hdl/sha1_dp.sv
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Chaining words, working variables, schedule window, bit length and the
// digest output buffer, all driven by controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sha1_pkg::t_dp_cmd i_cmd,
    input  wire logic [31:0]      i_data_word,
    input  wire logic [2:0]       i_byte_count,
    input  wire logic             i_last_item,
    output logic [31:0]           o_digest_word
);

    logic [31:0] r_chain [5];
    logic [31:0] r_var   [5];
    logic [31:0] r_win   [16];
    logic [31:0] r_dig   [5];
    logic [63:0] r_bitlen;

    logic [2:0]  nsat;
    logic [31:0] keep_mask;
    logic [31:0] mark_bits;
    logic [31:0] push_word;
    logic [5:0]  len_add;
    logic [31:0] sched_mix;
    logic [31:0] w_cur;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] tmp;
    logic        shift_en;
    logic [31:0] shift_in;

    // Mask and padding marker for a short final word.
    always_comb begin
        nsat = sha1_pkg::sat_count(i_byte_count);
        case (nsat)
            3'd0: begin
                keep_mask = 32'h00000000;
                mark_bits = 32'h80000000;
            end
            3'd1: begin
                keep_mask = 32'hff000000;
                mark_bits = 32'h00800000;
            end
            3'd2: begin
                keep_mask = 32'hffff0000;
                mark_bits = 32'h00008000;
            end
            3'd3: begin
                keep_mask = 32'hffffff00;
                mark_bits = 32'h00000080;
            end
            default: begin
                keep_mask = 32'hffffffff;
                mark_bits = 32'h00000000;
            end
        endcase
        len_add = i_last_item ? {nsat, 3'b000} : 6'd32;
    end

    // Word entering the schedule window.
    always_comb begin
        case (i_cmd.push_sel)
            sha1_pkg::PS_INPUT: begin
                if (i_last_item) begin
                    push_word = (i_data_word & keep_mask) | mark_bits;
                end else begin
                    push_word = i_data_word;
                end
            end
            sha1_pkg::PS_MARK:   push_word = sha1_pkg::PAD_MARK_WORD;
            sha1_pkg::PS_ZERO:   push_word = 32'h0;
            sha1_pkg::PS_LEN_HI: push_word = r_bitlen[63:32];
            sha1_pkg::PS_LEN_LO: push_word = r_bitlen[31:0];
            default:             push_word = 32'h0;
        endcase
    end

    // One SHA-1 round: message schedule, round function and sum.
    always_comb begin
        sched_mix = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        if (i_cmd.round_idx < 7'd16) begin
            w_cur = r_win[0];
        end else begin
            w_cur = {sched_mix[30:0], sched_mix[31]};
        end
        if (i_cmd.round_idx < 7'd20) begin
            f_val = (r_var[1] & r_var[2]) | (~r_var[1] & r_var[3]);
            k_val = sha1_pkg::K0;
        end else if (i_cmd.round_idx < 7'd40) begin
            f_val = r_var[1] ^ r_var[2] ^ r_var[3];
            k_val = sha1_pkg::K1;
        end else if (i_cmd.round_idx < 7'd60) begin
            f_val = (r_var[1] & r_var[2]) | (r_var[1] & r_var[3]) |
                    (r_var[2] & r_var[3]);
            k_val = sha1_pkg::K2;
        end else begin
            f_val = r_var[1] ^ r_var[2] ^ r_var[3];
            k_val = sha1_pkg::K3;
        end
        tmp = {r_var[0][26:0], r_var[0][31:27]} + f_val + r_var[4] + k_val + w_cur;
        shift_en = i_cmd.push | i_cmd.round_en;
        shift_in = i_cmd.push ? push_word : w_cur;
    end

    // Schedule window: a shift line, oldest word at entry 0.
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= shift_in;
        end
    end

    // Working variables a to e.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_var[i] <= 32'h0;
            end
        end else if (i_cmd.start_block) begin
            for (int i = 0; i < 5; i++) begin
                r_var[i] <= r_chain[i];
            end
        end else if (i_cmd.round_en) begin
            r_var[4] <= r_var[3];
            r_var[3] <= r_var[2];
            r_var[2] <= {r_var[1][1:0], r_var[1][31:2]};
            r_var[1] <= r_var[0];
            r_var[0] <= tmp;
        end
    end

    // Chaining words and message bit length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_chain[i] <= sha1_pkg::INIT_HASH[i];
            end
            r_bitlen <= 64'h0;
        end else begin
            if (i_cmd.digest_load) begin
                for (int i = 0; i < 5; i++) begin
                    r_chain[i] <= sha1_pkg::INIT_HASH[i];
                end
                r_bitlen <= 64'h0;
            end else begin
                if (i_cmd.chain_add) begin
                    for (int i = 0; i < 5; i++) begin
                        r_chain[i] <= r_chain[i] + r_var[i];
                    end
                end
                if (i_cmd.push && (i_cmd.push_sel == sha1_pkg::PS_INPUT)) begin
                    r_bitlen <= r_bitlen + 64'(len_add);
                end
            end
        end
    end

    // Digest buffer, shifted out one word per output handshake.
    always_ff @(posedge i_clk) begin
        if (i_cmd.digest_load) begin
            for (int i = 0; i < 5; i++) begin
                r_dig[i] <= r_chain[i];
            end
        end else if (i_cmd.out_shift) begin
            for (int i = 0; i < 4; i++) begin
                r_dig[i] <= r_dig[i + 1];
            end
        end
    end

    assign o_digest_word = r_dig[0];

endmodule

`default_nettype wire

>>> hdl/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences word intake, padding, the 80 rounds, the chaining update and the
// digest output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last_item,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_word_index,
    output logic             o_last_word,
    output sha1_pkg::t_dp_cmd o_cmd
);

    sha1_pkg::t_state r_state, n_state;
    sha1_pkg::t_state r_resume, n_resume;
    logic [3:0] r_count, n_count;
    logic [6:0] r_round, n_round;
    logic       r_out_busy;
    logic [2:0] r_out_idx;

    sha1_pkg::t_state nx_after;
    logic       push;
    logic       in_acc;
    logic       out_acc;
    logic [3:0] count_inc;

    assign o_in_ready = (r_state == sha1_pkg::S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign out_acc    = o_out_valid & i_out_ready;
    assign count_inc  = r_count + 4'd1;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha1_pkg::S_IDLE;
            r_resume <= sha1_pkg::S_IDLE;
            r_count  <= 4'd0;
            r_round  <= 7'd0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
            r_count  <= n_count;
            r_round  <= n_round;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state  = r_state;
        n_resume = r_resume;
        n_count  = r_count;
        n_round  = r_round;
        nx_after = r_state;
        push     = 1'b0;
        o_cmd    = '0;
        o_cmd.push_sel  = sha1_pkg::PS_INPUT;
        o_cmd.round_idx = r_round;
        o_cmd.out_shift = out_acc;
        case (r_state)
            sha1_pkg::S_IDLE: begin
                if (in_acc) begin
                    push = 1'b1;
                    o_cmd.push_sel = sha1_pkg::PS_INPUT;
                    if (!i_last_item) begin
                        nx_after = sha1_pkg::S_IDLE;
                    end else if (sha1_pkg::sat_count(i_byte_count) == sha1_pkg::FULL_BYTES) begin
                        nx_after = sha1_pkg::S_PAD_MARK;
                    end else if (count_inc == sha1_pkg::LEN_SLOT) begin
                        nx_after = sha1_pkg::S_LEN_HI;
                    end else begin
                        nx_after = sha1_pkg::S_PAD_ZERO;
                    end
                end
            end
            sha1_pkg::S_PAD_MARK: begin
                push = 1'b1;
                o_cmd.push_sel = sha1_pkg::PS_MARK;
                nx_after = (count_inc == sha1_pkg::LEN_SLOT) ? sha1_pkg::S_LEN_HI
                                                             : sha1_pkg::S_PAD_ZERO;
            end
            sha1_pkg::S_PAD_ZERO: begin
                push = 1'b1;
                o_cmd.push_sel = sha1_pkg::PS_ZERO;
                nx_after = (count_inc == sha1_pkg::LEN_SLOT) ? sha1_pkg::S_LEN_HI
                                                             : sha1_pkg::S_PAD_ZERO;
            end
            sha1_pkg::S_LEN_HI: begin
                push = 1'b1;
                o_cmd.push_sel = sha1_pkg::PS_LEN_HI;
                nx_after = sha1_pkg::S_LEN_LO;
            end
            sha1_pkg::S_LEN_LO: begin
                push = 1'b1;
                o_cmd.push_sel = sha1_pkg::PS_LEN_LO;
                nx_after = sha1_pkg::S_DONE;
            end
            sha1_pkg::S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (r_round == sha1_pkg::LAST_ROUND) begin
                    n_round = 7'd0;
                    n_state = sha1_pkg::S_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            sha1_pkg::S_ADD: begin
                o_cmd.chain_add = 1'b1;
                n_state = r_resume;
            end
            sha1_pkg::S_DONE: begin
                if (!r_out_busy) begin
                    o_cmd.digest_load = 1'b1;
                    n_state = sha1_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sha1_pkg::S_IDLE;
            end
        endcase

        // A push that fills the window starts a block compression.
        if (push) begin
            o_cmd.push = 1'b1;
            n_count = count_inc;
            if (r_count == sha1_pkg::LAST_SLOT) begin
                o_cmd.start_block = 1'b1;
                n_state  = sha1_pkg::S_ROUND;
                n_resume = nx_after;
            end else begin
                n_state = nx_after;
            end
        end
    end

    // Output word counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_busy <= 1'b0;
            r_out_idx  <= 3'd0;
        end else if (o_cmd.digest_load) begin
            r_out_busy <= 1'b1;
            r_out_idx  <= 3'd0;
        end else if (out_acc) begin
            if (r_out_idx == sha1_pkg::LAST_DIGEST_IDX) begin
                r_out_busy <= 1'b0;
                r_out_idx  <= 3'd0;
            end else begin
                r_out_idx <= r_out_idx + 3'd1;
            end
        end
    end

    assign o_out_valid  = r_out_busy;
    assign o_word_index = r_out_idx;
    assign o_last_word  = (r_out_idx == sha1_pkg::LAST_DIGEST_IDX);

`ifndef SYNTH
    // The final round hands over to the chaining update.
    a_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1_pkg::S_ROUND && r_round == sha1_pkg::LAST_ROUND)
        |=> (r_state == sha1_pkg::S_ADD))
        else $error("last round not followed by chaining update");

    // The low length word always completes a block.
    a_len_fills_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1_pkg::S_LEN_LO) |=> (r_state == sha1_pkg::S_ROUND))
        else $error("length words did not end a block");

    // A digest load starts a fresh output sequence.
    a_load_starts_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.digest_load |=> (r_out_busy && r_out_idx == 3'd0))
        else $error("digest load did not start output");

    // The fifth digest word taken frees the buffer.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_word) |=> !r_out_busy)
        else $error("buffer still busy after final digest word");
`endif

endmodule

`default_nettype wire
